@@ rtl/fbpa_pkg.sv @@
// Shared types, widths and defaults for the fixed block pool allocator.
package fbpa_pkg;

    // Field widths of the transaction payloads and the configuration register.
    localparam int OP_W         = 2;
    localparam int REQ_SIZE_W   = 16;
    localparam int ADDR_W       = 18;
    localparam int STATUS_W     = 2;
    localparam int BLOCK_SIZE_W = 13;

    // Reset value of the block size register.
    localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = 13'd64;

    // Default geometry of the pool chain.
    localparam int DEF_BLOCKS_PER_POOL = 16;
    localparam int DEF_MAX_POOLS       = 4;

    // Operation codes carried by a request.
    typedef enum logic [OP_W-1:0] {
        OP_BORROW  = 2'd0,
        OP_RESTORE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 2'd0,
        STS_NO_FREE  = 2'd1,
        STS_FOREIGN  = 2'd2,
        STS_OVERFLOW = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_BUILD,
        ST_IDLE,
        ST_SPAN,
        ST_SCAN,
        ST_POP,
        ST_PUSH,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/fbpa_if.sv @@
// Channel interfaces for requests, results and block size configuration.
interface fbpa_req_if;
    import fbpa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [REQ_SIZE_W-1:0] requested_size;
    logic [ADDR_W-1:0]     block_address;

    modport source (output valid, op, requested_size, block_address, input ready);
    modport sink   (input valid, op, requested_size, block_address, output ready);
endinterface

interface fbpa_rsp_if;
    import fbpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_address;
    logic                size_mismatch;

    modport source (output valid, status, granted_address, size_mismatch, input ready);
    modport sink   (input valid, status, granted_address, size_mismatch, output ready);
endinterface

interface fbpa_cfg_if;
    import fbpa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [BLOCK_SIZE_W-1:0] block_size;

    modport source (output valid, block_size, input ready);
    modport sink   (input valid, block_size, output ready);
endinterface

@@ rtl/fbpa_stack_mem.sv @@
// Single write port, single registered read port memory holding the free stacks.
module fbpa_stack_mem #(
    parameter int DEPTH = fbpa_pkg::DEF_MAX_POOLS * fbpa_pkg::DEF_BLOCKS_PER_POOL,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [IDX_W-1:0]           wr_idx,
    input  logic [fbpa_pkg::ADDR_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [IDX_W-1:0]           rd_idx,
    output logic [fbpa_pkg::ADDR_W-1:0] rd_data
);
    import fbpa_pkg::*;

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/fixed_block_pool_allocator.sv @@
// Fixed block pool allocator: a chain of up to MAX_POOLS pools, each with a LIFO stack of free
// block addresses, run by a small sequencer around one stack memory and one bound adder. One
// transaction is worked on at a time and req.ready is high only while the sequencer is idle.
// After reset, pool 0 is built before any request is taken. A borrow goes from acceptance
// through span setup, a scan of each pool visited, the stack pop and the result load; when a
// new pool must be activated its stack is rebuilt one entry per cycle before the pop. A borrow
// that finds every pool exhausted ends its scan with a no-free status. A restore scans for the
// pool whose range holds the address and pushes it there, or is refused when that pool is full;
// a foreign address is reported after the active pools are scanned, or without scanning any
// pool when the block size is zero. A clear rebuilds pool 0 and leaves it as the only active
// pool, and the undefined op goes straight to the result. A finished result waits in an output
// register while the next request is accepted.
module fixed_block_pool_allocator #(
    parameter int BLOCKS_PER_POOL = fbpa_pkg::DEF_BLOCKS_PER_POOL,
    parameter int MAX_POOLS       = fbpa_pkg::DEF_MAX_POOLS
) (
    input  logic      clk,
    input  logic      rst_n,
    fbpa_req_if.sink   req,
    fbpa_rsp_if.source rsp,
    fbpa_cfg_if.sink   cfg
);
    import fbpa_pkg::*;

    localparam int PIW    = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
    localparam int PCW    = $clog2(MAX_POOLS + 1);
    localparam int CW     = $clog2(BLOCKS_PER_POOL + 1);
    localparam int DEPTH  = MAX_POOLS * BLOCKS_PER_POOL;
    localparam int MW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SPAN_W = BLOCK_SIZE_W + CW;
    localparam int BW     = SPAN_W + PCW;

    localparam logic [CW-1:0]  COUNT_FULL = CW'(BLOCKS_PER_POOL);
    localparam logic [CW-1:0]  SLOT_LAST  = CW'(BLOCKS_PER_POOL - 1);
    localparam logic [PCW-1:0] POOLS_MAX  = PCW'(MAX_POOLS);

    // Flat stack index of a slot within a pool.
    function automatic logic [MW-1:0] stack_idx(input logic [PIW-1:0] pool,
                                                input logic [CW-1:0] slot);
        return MW'(int'(pool) * BLOCKS_PER_POOL + int'(slot));
    endfunction

    state_t                  state_reg, state_next;
    logic                    init_reg, init_next;
    op_t                     op_reg, op_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic                    mismatch_reg, mismatch_next;
    status_t                 status_reg, status_next;
    logic                    grant_en_reg, grant_en_next;
    logic [PCW-1:0]          pool_reg, pool_next;
    logic [PCW-1:0]          active_reg, active_next;
    logic [BW-1:0]           base_reg, base_next;
    logic [SPAN_W-1:0]       span_reg, span_next;
    logic [CW-1:0]           slot_reg, slot_next;
    logic [ADDR_W-1:0]       build_addr_reg, build_addr_next;
    logic [BLOCK_SIZE_W-1:0] step_reg, step_next;
    logic [CW-1:0]           count_reg [MAX_POOLS];
    logic [CW-1:0]           count_next [MAX_POOLS];
    logic [BLOCK_SIZE_W-1:0] block_size_reg;

    logic                    rsp_valid_reg, rsp_valid_next;
    status_t                 rsp_status_reg, rsp_status_next;
    logic [ADDR_W-1:0]       rsp_grant_reg, rsp_grant_next;
    logic                    rsp_mismatch_reg, rsp_mismatch_next;

    logic                    mem_wr_en;
    logic [MW-1:0]           mem_wr_idx;
    logic [ADDR_W-1:0]       mem_wr_data;
    logic                    mem_rd_en;
    logic [MW-1:0]           mem_rd_idx;
    logic [ADDR_W-1:0]       mem_rd_data;

    logic [PIW-1:0]          pool_idx;
    logic [CW-1:0]           count_cur;
    logic [BW-1:0]           bound_hi;

    fbpa_stack_mem #(
        .DEPTH (DEPTH),
        .IDX_W (MW)
    ) u_stack_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_idx  (mem_wr_idx),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_idx  (mem_rd_idx),
        .rd_data (mem_rd_data)
    );

    // Configuration register; writes are taken in any cycle.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            block_size_reg <= cfg.block_size;
        end
    end

    // Current pool's fill level and the upper bound of its address range.
    assign pool_idx  = pool_reg[PIW-1:0];
    assign count_cur = count_reg[pool_idx];
    assign bound_hi  = base_reg + BW'(span_reg);

    // Handshake outputs.
    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.granted_address = rsp_grant_reg;
    assign rsp.size_mismatch   = rsp_mismatch_reg;

    // Sequencer: next state, datapath updates and memory port control.
    always_comb
    begin
        state_next        = state_reg;
        init_next         = init_reg;
        op_next           = op_reg;
        addr_next         = addr_reg;
        mismatch_next     = mismatch_reg;
        status_next       = status_reg;
        grant_en_next     = grant_en_reg;
        pool_next         = pool_reg;
        active_next       = active_reg;
        base_next         = base_reg;
        span_next         = span_reg;
        slot_next         = slot_reg;
        build_addr_next   = build_addr_reg;
        step_next         = step_reg;
        count_next        = count_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        rsp_status_next   = rsp_status_reg;
        rsp_grant_next    = rsp_grant_reg;
        rsp_mismatch_next = rsp_mismatch_reg;
        mem_wr_en         = 1'b0;
        mem_wr_idx        = stack_idx(pool_idx, slot_reg);
        mem_wr_data       = build_addr_reg;
        mem_rd_en         = 1'b0;
        mem_rd_idx        = stack_idx(pool_idx, CW'(count_cur - 1'b1));

        case (state_reg)
            ST_BUILD:
            begin
                // Rebuild one stack entry per cycle in ascending address order.
                mem_wr_en       = 1'b1;
                slot_next       = CW'(slot_reg + 1'b1);
                build_addr_next = build_addr_reg + ADDR_W'(step_reg);
                if (slot_reg == SLOT_LAST)
                begin
                    count_next[pool_idx] = COUNT_FULL;
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else if (op_reg == OP_CLEAR)
                    begin
                        active_next = PCW'(1);
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = op_t'(req.op);
                    addr_next       = req.block_address;
                    mismatch_next   = (op_t'(req.op) == OP_BORROW) &&
                                      (req.requested_size != REQ_SIZE_W'(block_size_reg));
                    status_next     = STS_OK;
                    grant_en_next   = 1'b0;
                    pool_next       = '0;
                    base_next       = '0;
                    slot_next       = '0;
                    build_addr_next = '0;
                    step_next       = block_size_reg;
                    case (op_t'(req.op))
                        OP_BORROW:  state_next = ST_SPAN;
                        OP_RESTORE: state_next = ST_SPAN;
                        OP_CLEAR:   state_next = ST_BUILD;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end

            ST_SPAN:
            begin
                // Size of one pool's address range.
                span_next  = SPAN_W'(block_size_reg * BLOCKS_PER_POOL);
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (op_reg == OP_BORROW)
                begin
                    // Walk the active pools for one with a free block.
                    if (pool_reg < active_reg)
                    begin
                        if (count_cur != '0)
                        begin
                            state_next = ST_POP;
                        end
                        else
                        begin
                            pool_next = PCW'(pool_reg + 1'b1);
                            base_next = bound_hi;
                        end
                    end
                    else if (active_reg < POOLS_MAX)
                    begin
                        active_next     = PCW'(active_reg + 1'b1);
                        build_addr_next = base_reg[ADDR_W-1:0];
                        slot_next       = '0;
                        state_next      = ST_BUILD;
                    end
                    else
                    begin
                        status_next = STS_NO_FREE;
                        state_next  = ST_FINISH;
                    end
                end
                else
                begin
                    // Find the active pool whose range holds the address.
                    if (span_reg == '0)
                    begin
                        status_next = STS_FOREIGN;
                        state_next  = ST_FINISH;
                    end
                    else if (pool_reg < active_reg)
                    begin
                        if (BW'(addr_reg) < bound_hi)
                        begin
                            if (count_cur >= COUNT_FULL)
                            begin
                                status_next = STS_OVERFLOW;
                                state_next  = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_PUSH;
                            end
                        end
                        else
                        begin
                            pool_next = PCW'(pool_reg + 1'b1);
                            base_next = bound_hi;
                        end
                    end
                    else
                    begin
                        status_next = STS_FOREIGN;
                        state_next  = ST_FINISH;
                    end
                end
            end

            ST_POP:
            begin
                // Read the top of the stack and drop it.
                mem_rd_en            = 1'b1;
                count_next[pool_idx] = CW'(count_cur - 1'b1);
                grant_en_next        = 1'b1;
                state_next           = ST_FINISH;
            end

            ST_PUSH:
            begin
                // Put the restored address on top of the stack.
                mem_wr_en            = 1'b1;
                mem_wr_idx           = stack_idx(pool_idx, count_cur);
                mem_wr_data          = addr_reg;
                count_next[pool_idx] = CW'(count_cur + 1'b1);
                state_next           = ST_FINISH;
            end

            ST_FINISH:
            begin
                // Load the result once the output register is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_status_next   = status_reg;
                    rsp_grant_next    = grant_en_reg ? mem_rd_data : '0;
                    rsp_mismatch_next = mismatch_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_BUILD;
            init_reg       <= 1'b1;
            op_reg         <= OP_NOP;
            pool_reg       <= '0;
            active_reg     <= PCW'(1);
            slot_reg       <= '0;
            build_addr_reg <= '0;
            step_reg       <= BLOCK_SIZE_RESET;
            grant_en_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_POOLS; i++)
            begin
                count_reg[i] <= COUNT_FULL;
            end
        end
        else
        begin
            state_reg      <= state_next;
            init_reg       <= init_next;
            op_reg         <= op_next;
            pool_reg       <= pool_next;
            active_reg     <= active_next;
            slot_reg       <= slot_next;
            build_addr_reg <= build_addr_next;
            step_reg       <= step_next;
            grant_en_reg   <= grant_en_next;
            rsp_valid_reg  <= rsp_valid_next;
            count_reg      <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg         <= addr_next;
        mismatch_reg     <= mismatch_next;
        status_reg       <= status_next;
        base_reg         <= base_next;
        span_reg         <= span_next;
        rsp_status_reg   <= rsp_status_next;
        rsp_grant_reg    <= rsp_grant_next;
        rsp_mismatch_reg <= rsp_mismatch_next;
    end

endmodule

@@ rtl/fbpa_checker.sv @@
// Port-level checks for the fixed block pool allocator and their binding to it.
module fbpa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [fbpa_pkg::STATUS_W-1:0] rsp_status,
    input logic [fbpa_pkg::ADDR_W-1:0]   rsp_granted_address,
    input logic                          rsp_size_mismatch
);
    import fbpa_pkg::*;

    // A result held back by the sink stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
            $stable(rsp_granted_address) && $stable(rsp_size_mismatch))
        else $error("result changed while stalled");

    // The sequencer is busy right after it takes a request.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    // Only a successful borrow hands out a nonzero address.
    a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_granted_address != '0) |-> rsp_status == STS_OK)
        else $error("address granted with failing status");

    // The size flag belongs to borrows, which never report restore errors.
    a_mismatch_borrow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_size_mismatch |->
            (rsp_status == STS_OK) || (rsp_status == STS_NO_FREE))
        else $error("size flag on a restore result");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_granted_address (rsp.granted_address),
    .rsp_size_mismatch   (rsp.size_mismatch)
);
